/* design/parametric_eq_coefficient_encoder_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the peaking-EQ coefficient encoder
// Same-cycle and next-cycle implication checks, reported by $error.
// ----------------------------------------------------------------------------
`ifndef PARAMETRIC_EQ_COEFFICIENT_ENCODER_CORE_ASSERT_SVH
`define PARAMETRIC_EQ_COEFFICIENT_ENCODER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PEQCE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PEQCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/peqce_pkg.sv */
// ----------------------------------------------------------------------------
// peqce_pkg
// Shared types, constants and small functions of the peaking-EQ encoder.
// ----------------------------------------------------------------------------
package peqce_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_SAMPLE_RATE = 1'b0;
   localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;

   localparam int FS_W     = 18;
   localparam int DVD_W    = 31;   // center_freq << 16
   localparam int PHASE_W  = 16;
   localparam int CORDIC_W = 34;
   localparam int MAX_STAGES = 24;
   localparam int SC_W     = 17;   // sin/cos after quadrant map
   localparam int PROD_W   = 38;
   localparam int ND_W     = 46;
   localparam int MAG_W    = 44;
   localparam int QUO2_W   = 12;

   localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;
   localparam logic signed [7:0] K0_OFFSET = 8'sd31;
   localparam logic [3:0] ADDR_BASE = 4'h5;
   localparam logic [10:0] M1_MAX = 11'd2047;
   localparam logic [3:0]  E1_MAX = 4'd15;
   localparam logic [3:0]  M2_MAX = 4'd15;
   localparam logic [2:0]  E2_MAX = 3'd7;

   localparam logic [31:0] ATAN_TURN [0:MAX_STAGES-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef logic signed [CORDIC_W-1:0] cordic_word_type;

   typedef struct packed {
      logic [3:0]  addr;
      logic [6:0]  k0;
      logic [2:0]  pexp;
      logic [11:0] q;
   } front_type;

   typedef struct packed {
      logic [1:0] quad;
      front_type  front;
   } rot_pay_type;

   typedef struct packed {
      logic [15:0] word_one;
      logic [3:0]  addr;
      logic [6:0]  k0;
      logic        t2;
      logic        dzero;
      logic        ge;
   } ratio_pay_type;

   // cut depth in decades: floor(mag / 10), capped at 6
   function automatic logic [2:0] cut_decades(input logic [6:0] mag);
      logic [2:0] p;
      begin
         if (mag >= 7'd60)      p = 3'd6;
         else if (mag >= 7'd50) p = 3'd5;
         else if (mag >= 7'd40) p = 3'd4;
         else if (mag >= 7'd30) p = 3'd3;
         else if (mag >= 7'd20) p = 3'd2;
         else if (mag >= 7'd10) p = 3'd1;
         else                   p = 3'd0;
         return p;
      end
   endfunction

   function automatic logic [19:0] pow10(input logic [2:0] p);
      logic [19:0] v;
      begin
         case (p)
            3'd0:    v = 20'd1;
            3'd1:    v = 20'd10;
            3'd2:    v = 20'd100;
            3'd3:    v = 20'd1000;
            3'd4:    v = 20'd10000;
            3'd5:    v = 20'd100000;
            default: v = 20'd1000000;
         endcase
         return v;
      end
   endfunction

   // round half up to Q1.15, saturate
   function automatic logic signed [SC_W-1:0] to_q15(input cordic_word_type v);
      cordic_word_type r;
      logic signed [SC_W-1:0] o;
      begin
         r = (v + cordic_word_type'(16384)) >>> 15;
         if (r > cordic_word_type'(32767))       o = 17'sd32767;
         else if (r < -cordic_word_type'(32768)) o = -17'sd32768;
         else                                    o = r[SC_W-1:0];
         return o;
      end
   endfunction

endpackage

/* design/parametric_eq_coefficient_encoder_core.sv */
// ----------------------------------------------------------------------------
// parametric_eq_coefficient_encoder_core
// Peaking-EQ band request in, two packed coefficient words and address out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one band request (band, center freq, gain, Q) per item.
//  - rsp_* channel: the item's two coefficient words and word-one register.
//  - APB port: register 0 is the sample rate (reset 48000); write only while
//    no item is in flight.
//  - Fully pipelined: one item per cycle sustained while req_stall is low.
//    An accepted item crosses the input register, the 31-step phase
//    divider, the CORDIC row (at most 24 cells), five arithmetic stages,
//    the 12-step ratio divider and the output register.
//  - Whole pipeline advances together. When rsp_stall holds an item in the
//    output register, the next finished item drops into a skid register and
//    req_stall rises until the skid drains; nothing is lost or repeated.
//  - Reset (synchronous) empties the pipeline, drops rsp_valid and restores
//    the sample rate to 48000.
// ----------------------------------------------------------------------------
`include "parametric_eq_coefficient_encoder_core_assert.svh"

module parametric_eq_coefficient_encoder_core #(
   parameter int NUM_BANDS     = 5,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_band,
   input  logic [14:0]                      req_center_freq_hz,
   input  logic signed [6:0]                req_gain_db,
   input  logic [11:0]                      req_q_factor,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [15:0]                      rsp_coeff_word_one,
   output logic [15:0]                      rsp_coeff_word_two,
   output logic [3:0]                       rsp_register_address,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [peqce_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int NSTG = (CORDIC_STAGES > peqce_pkg::MAX_STAGES) ?
                         peqce_pkg::MAX_STAGES : CORDIC_STAGES;
   localparam logic [3:0] BAND_MAX = 4'(NUM_BANDS - 1);
   localparam int FRONT_W = $bits(peqce_pkg::front_type);
   localparam int ROT_W   = $bits(peqce_pkg::rot_pay_type);
   localparam int RAT_W   = $bits(peqce_pkg::ratio_pay_type);

   // ---------------- configuration ----------------
   logic [peqce_pkg::FS_W-1:0] fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= peqce_pkg::SAMPLE_RATE_RESET;
      end else if (psel && penable && pwrite &&
                   paddr[2] == peqce_pkg::CSR_IDX_SAMPLE_RATE) begin
         fs_ff <= pwdata[peqce_pkg::FS_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == peqce_pkg::CSR_IDX_SAMPLE_RATE) ?
                   {14'd0, fs_ff} : 32'd0;

   // ---------------- flow control ----------------
   // every pipeline register moves only while the skid slot is free
   logic skid_valid_ff, adv;
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------- input stage ----------------
   logic [3:0]             band_ext, band_sat;
   logic signed [7:0]      k0_wide;
   logic [6:0]             cut_mag;
   peqce_pkg::front_type   front_in, s0_front_ff;
   logic                   s0_valid_ff;
   logic [14:0]            s0_fc_ff;

   always_comb begin
      band_ext = {1'b0, req_band};
      band_sat = (band_ext > BAND_MAX) ? BAND_MAX : band_ext;
      k0_wide  = 8'(req_gain_db) + peqce_pkg::K0_OFFSET;
      cut_mag  = 7'(-req_gain_db);
      front_in.addr = peqce_pkg::ADDR_BASE + {band_sat[2:0], 1'b0};
      front_in.k0   = k0_wide[7] ? 7'd0 : k0_wide[6:0];
      front_in.pexp = req_gain_db[6] ? peqce_pkg::cut_decades(cut_mag) : 3'd0;
      front_in.q    = req_q_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
      if (adv) begin
         s0_front_ff <= front_in;
         s0_fc_ff    <= req_center_freq_hz;
      end
   end

   // ---------------- phase divider: floor(fc*65536 / Fs) mod 2^16 ----------
   logic                             pd_valid [0:peqce_pkg::DVD_W];
   logic [peqce_pkg::FS_W-1:0]       pd_rem   [0:peqce_pkg::DVD_W];
   logic [peqce_pkg::FS_W-1:0]       pd_den   [0:peqce_pkg::DVD_W];
   logic [peqce_pkg::DVD_W-1:0]      pd_dvd   [0:peqce_pkg::DVD_W];
   logic [peqce_pkg::PHASE_W-1:0]    pd_quo   [0:peqce_pkg::DVD_W];
   logic [FRONT_W-1:0]               pd_pay   [0:peqce_pkg::DVD_W];

   assign pd_valid[0] = s0_valid_ff;
   assign pd_rem[0]   = '0;
   assign pd_den[0]   = fs_ff;
   assign pd_dvd[0]   = {s0_fc_ff, 16'd0};
   assign pd_quo[0]   = '0;
   assign pd_pay[0]   = s0_front_ff;

   for (genvar i = 0; i < peqce_pkg::DVD_W; i++) begin : g_phase_div
      peqce_div_cell #(
         .RW(peqce_pkg::FS_W), .DW(peqce_pkg::DVD_W),
         .QW(peqce_pkg::PHASE_W), .PW(FRONT_W)
      ) u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .in_valid(pd_valid[i]), .in_rem(pd_rem[i]), .in_den(pd_den[i]),
         .in_dvd(pd_dvd[i]), .in_quo(pd_quo[i]), .in_pay(pd_pay[i]),
         .out_valid(pd_valid[i+1]), .out_rem(pd_rem[i+1]), .out_den(pd_den[i+1]),
         .out_dvd(pd_dvd[i+1]), .out_quo(pd_quo[i+1]), .out_pay(pd_pay[i+1])
      );
   end

   // zero sample rate gives phase 0
   logic [peqce_pkg::PHASE_W-1:0] phase;
   assign phase = (fs_ff == '0) ? '0 : pd_quo[peqce_pkg::DVD_W];

   // ---------------- CORDIC row ----------------
   logic                       cr_valid [0:NSTG];
   peqce_pkg::cordic_word_type cr_x     [0:NSTG];
   peqce_pkg::cordic_word_type cr_y     [0:NSTG];
   peqce_pkg::cordic_word_type cr_z     [0:NSTG];
   logic [ROT_W-1:0]           cr_pay   [0:NSTG];
   peqce_pkg::rot_pay_type     rot_in;

   always_comb begin
      rot_in.quad  = phase[15:14];
      rot_in.front = pd_pay[peqce_pkg::DVD_W];
   end

   assign cr_valid[0] = pd_valid[peqce_pkg::DVD_W];
   assign cr_x[0]     = peqce_pkg::cordic_word_type'({2'b00, peqce_pkg::CORDIC_X0});
   assign cr_y[0]     = '0;
   assign cr_z[0]     = peqce_pkg::cordic_word_type'({4'd0, phase[13:0], 16'd0});
   assign cr_pay[0]   = rot_in;

   for (genvar i = 0; i < NSTG; i++) begin : g_cordic
      peqce_cordic_cell #(.STAGE(i), .PW(ROT_W)) u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .in_valid(cr_valid[i]), .in_x(cr_x[i]), .in_y(cr_y[i]), .in_z(cr_z[i]),
         .in_pay(cr_pay[i]),
         .out_valid(cr_valid[i+1]), .out_x(cr_x[i+1]), .out_y(cr_y[i+1]),
         .out_z(cr_z[i+1]), .out_pay(cr_pay[i+1])
      );
   end

   // ---------------- round and quadrant map ----------------
   peqce_pkg::rot_pay_type         rot_out;
   logic signed [peqce_pkg::SC_W-1:0] cq, sq, sin_in, cos_in, sin_ff, cos_ff;
   logic                           sc_valid_ff;
   peqce_pkg::front_type           sc_front_ff;

   always_comb begin
      rot_out = cr_pay[NSTG];
      cq = peqce_pkg::to_q15(cr_x[NSTG]);
      sq = peqce_pkg::to_q15(cr_y[NSTG]);
      case (rot_out.quad)
         2'd0:    begin cos_in = cq;  sin_in = sq;  end
         2'd1:    begin cos_in = -sq; sin_in = cq;  end
         2'd2:    begin cos_in = -cq; sin_in = -sq; end
         default: begin cos_in = sq;  sin_in = -cq; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (adv) begin
         sc_valid_ff <= cr_valid[NSTG];
      end
      if (adv) begin
         sin_ff      <= sin_in;
         cos_ff      <= cos_in;
         sc_front_ff <= rot_out.front;
      end
   end

   // ---------------- K1 coding and sin * 10^p ----------------
   logic [16:0] c_mag;
   logic [15:0] m1;
   logic [3:0]  e1;
   logic [31:0] m1_sh, m1_wide;
   logic [10:0] mant1;
   logic [15:0] word_one_in, word_one_ff;
   logic signed [20:0] pw_s;
   logic signed [peqce_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic        k1_valid_ff;
   logic [3:0]  k1_addr_ff;
   logic [6:0]  k1_k0_ff;
   logic [11:0] k1_q_ff;

   always_comb begin
      c_mag = cos_ff[16] ? 17'(-cos_ff) : 17'(cos_ff);
      m1    = 16'(17'd32768 - c_mag);
      e1    = peqce_pkg::E1_MAX;
      for (int e = 15; e >= 0; e--) begin
         if (({16'd0, m1} << e) >= 32'd16384) e1 = 4'(e);
      end
      m1_sh   = {16'd0, m1} << e1;
      m1_wide = m1_sh >> 4;
      mant1   = (m1_wide > {21'd0, peqce_pkg::M1_MAX}) ? peqce_pkg::M1_MAX
                                                       : m1_wide[10:0];
      word_one_in = {cos_ff[16], mant1, e1};
      // product formed at full width by the assignment context
      pw_s    = $signed({1'b0, peqce_pkg::pow10(sc_front_ff.pexp)});
      prod_in = sin_ff * pw_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff <= 1'b0;
      end else if (adv) begin
         k1_valid_ff <= sc_valid_ff;
      end
      if (adv) begin
         word_one_ff <= word_one_in;
         prod_ff     <= prod_in;
         k1_addr_ff  <= sc_front_ff.addr;
         k1_k0_ff    <= sc_front_ff.k0;
         k1_q_ff     <= sc_front_ff.q;
      end
   end

   // ---------------- N = a - b, D = a + b ----------------
   logic signed [peqce_pkg::ND_W-1:0] a_val, b_val, n_ff, d_ff;
   logic          nd_valid_ff;
   logic [15:0]   nd_word_one_ff;
   logic [3:0]    nd_addr_ff;
   logic [6:0]    nd_k0_ff;

   assign a_val = $signed({18'd0, k1_q_ff, 16'd0});
   assign b_val = $signed({prod_ff, 8'd0});

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_valid_ff <= 1'b0;
      end else if (adv) begin
         nd_valid_ff <= k1_valid_ff;
      end
      if (adv) begin
         n_ff           <= a_val - b_val;
         d_ff           <= a_val + b_val;
         nd_word_one_ff <= word_one_ff;
         nd_addr_ff     <= k1_addr_ff;
         nd_k0_ff       <= k1_k0_ff;
      end
   end

   // ---------------- magnitudes and K2 sign ----------------
   logic [peqce_pkg::ND_W-1:0]  n_abs, d_abs;
   logic [peqce_pkg::MAG_W-1:0] an_ff, ad_ff;
   logic          ab_valid_ff, ab_t2_ff, ab_dzero_ff, dzero_in;
   logic [15:0]   ab_word_one_ff;
   logic [3:0]    ab_addr_ff;
   logic [6:0]    ab_k0_ff;

   always_comb begin
      n_abs    = n_ff[peqce_pkg::ND_W-1] ? 46'(-n_ff) : 46'(n_ff);
      d_abs    = d_ff[peqce_pkg::ND_W-1] ? 46'(-d_ff) : 46'(d_ff);
      dzero_in = (d_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ab_valid_ff <= 1'b0;
      end else if (adv) begin
         ab_valid_ff <= nd_valid_ff;
      end
      if (adv) begin
         an_ff          <= n_abs[peqce_pkg::MAG_W-1:0];
         ad_ff          <= d_abs[peqce_pkg::MAG_W-1:0];
         ab_dzero_ff    <= dzero_in;
         // same strict sign on N and D, N nonzero
         ab_t2_ff       <= !dzero_in && (n_ff != '0) &&
                           (n_ff[peqce_pkg::ND_W-1] == d_ff[peqce_pkg::ND_W-1]);
         ab_word_one_ff <= nd_word_one_ff;
         ab_addr_ff     <= nd_addr_ff;
         ab_k0_ff       <= nd_k0_ff;
      end
   end

   // ---------------- |K2| >= 1 test and 1 - |K2| numerator ----------------
   logic [peqce_pkg::MAG_W-1:0] num_ff, den_ff;
   logic                        cm_valid_ff;
   peqce_pkg::ratio_pay_type    cm_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_valid_ff <= 1'b0;
      end else if (adv) begin
         cm_valid_ff <= ab_valid_ff;
      end
      if (adv) begin
         num_ff             <= ad_ff - an_ff;
         den_ff             <= ad_ff;
         cm_pay_ff.word_one <= ab_word_one_ff;
         cm_pay_ff.addr     <= ab_addr_ff;
         cm_pay_ff.k0       <= ab_k0_ff;
         cm_pay_ff.t2       <= ab_t2_ff;
         cm_pay_ff.dzero    <= ab_dzero_ff;
         cm_pay_ff.ge       <= an_ff >= ad_ff;
      end
   end

   // ---------------- ratio divider: floor(num * 2^11 / den) ----------------
   logic                          kd_valid [0:peqce_pkg::QUO2_W];
   logic [peqce_pkg::MAG_W-1:0]   kd_rem   [0:peqce_pkg::QUO2_W];
   logic [peqce_pkg::MAG_W-1:0]   kd_den   [0:peqce_pkg::QUO2_W];
   logic [0:0]                    kd_dvd   [0:peqce_pkg::QUO2_W];
   logic [peqce_pkg::QUO2_W-1:0]  kd_quo   [0:peqce_pkg::QUO2_W];
   logic [RAT_W-1:0]              kd_pay   [0:peqce_pkg::QUO2_W];

   // first step sees num itself: rem = num >> 1 with num[0] shifted back in
   assign kd_valid[0] = cm_valid_ff;
   assign kd_rem[0]   = num_ff >> 1;
   assign kd_den[0]   = den_ff;
   assign kd_dvd[0]   = num_ff[0];
   assign kd_quo[0]   = '0;
   assign kd_pay[0]   = cm_pay_ff;

   for (genvar i = 0; i < peqce_pkg::QUO2_W; i++) begin : g_ratio_div
      peqce_div_cell #(
         .RW(peqce_pkg::MAG_W), .DW(1), .QW(peqce_pkg::QUO2_W), .PW(RAT_W)
      ) u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .in_valid(kd_valid[i]), .in_rem(kd_rem[i]), .in_den(kd_den[i]),
         .in_dvd(kd_dvd[i]), .in_quo(kd_quo[i]), .in_pay(kd_pay[i]),
         .out_valid(kd_valid[i+1]), .out_rem(kd_rem[i+1]), .out_den(kd_den[i+1]),
         .out_dvd(kd_dvd[i+1]), .out_quo(kd_quo[i+1]), .out_pay(kd_pay[i+1])
      );
   end

   // ---------------- K2 coding and packing ----------------
   peqce_pkg::ratio_pay_type     fin_pay;
   logic [peqce_pkg::QUO2_W-1:0] q11, m2_wide;
   logic [2:0]  e2, e2_out;
   logic [3:0]  mant2, mant2_out;
   logic        t2_out;
   logic        pipe_valid;
   logic [15:0] word_two;

   always_comb begin
      fin_pay = kd_pay[peqce_pkg::QUO2_W];
      q11     = kd_quo[peqce_pkg::QUO2_W];
      // fewest doublings bringing the ratio to at least one half
      e2 = peqce_pkg::E2_MAX;
      for (int e = 7; e >= 0; e--) begin
         if (q11 >= (12'd1 << (10 - e))) e2 = 3'(e);
      end
      m2_wide = q11 >> (3'd7 - e2);
      mant2   = (m2_wide > {8'd0, peqce_pkg::M2_MAX}) ? peqce_pkg::M2_MAX
                                                      : m2_wide[3:0];
      t2_out    = fin_pay.t2;
      e2_out    = e2;
      mant2_out = mant2;
      if (fin_pay.dzero) begin
         t2_out    = 1'b0;
         e2_out    = 3'd0;
         mant2_out = peqce_pkg::M2_MAX;
      end else if (fin_pay.ge) begin
         e2_out    = peqce_pkg::E2_MAX;
         mant2_out = 4'd0;
      end
      word_two   = {t2_out, mant2_out, e2_out, fin_pay.k0, 1'b0};
      pipe_valid = kd_valid[peqce_pkg::QUO2_W];
   end

   // ---------------- output register and skid ----------------
   logic        rsp_valid_ff;
   logic [15:0] rsp_w1_ff, rsp_w2_ff, skid_w1_ff, skid_w2_ff;
   logic [3:0]  rsp_addr_ff, skid_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= pipe_valid;
         end
      end else if (pipe_valid && adv) begin
         skid_valid_ff <= 1'b1;
      end

      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_w1_ff   <= skid_w1_ff;
            rsp_w2_ff   <= skid_w2_ff;
            rsp_addr_ff <= skid_addr_ff;
         end else begin
            rsp_w1_ff   <= fin_pay.word_one;
            rsp_w2_ff   <= word_two;
            rsp_addr_ff <= fin_pay.addr;
         end
      end else if (adv) begin
         skid_w1_ff   <= fin_pay.word_one;
         skid_w2_ff   <= word_two;
         skid_addr_ff <= fin_pay.addr;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_coeff_word_one   = rsp_w1_ff;
   assign rsp_coeff_word_two   = rsp_w2_ff;
   assign rsp_register_address = rsp_addr_ff;

   // ---------------- checks ----------------
   `PEQCE_ASSERT_SAME(a_skid_behind_out, clock, reset,
      skid_valid_ff, rsp_valid_ff, "skid item held with output register empty")
   `PEQCE_ASSERT_NEXT(a_skid_drains, clock, reset,
      rsp_valid_ff && !rsp_stall && skid_valid_ff, rsp_valid_ff && !skid_valid_ff,
      "skid item not moved to output after handoff")
   `PEQCE_ASSERT_SAME(a_addr_odd, clock, reset,
      rsp_valid_ff, rsp_addr_ff[0], "word-one register address is even")
   `PEQCE_ASSERT_SAME(a_word_two_lsb, clock, reset,
      rsp_valid_ff, !rsp_w2_ff[0], "coefficient word two bit 0 set")

endmodule

/* design/peqce_div_cell.sv */
// ----------------------------------------------------------------------------
// peqce_div_cell
// One restoring-division step: shift in a dividend bit, compare, subtract.
// ----------------------------------------------------------------------------
module peqce_div_cell #(
   parameter int RW = 18,
   parameter int DW = 31,
   parameter int QW = 16,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [RW-1:0] in_rem,
   input  logic [RW-1:0] in_den,
   input  logic [DW-1:0] in_dvd,
   input  logic [QW-1:0] in_quo,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [RW-1:0] out_rem,
   output logic [RW-1:0] out_den,
   output logic [DW-1:0] out_dvd,
   output logic [QW-1:0] out_quo,
   output logic [PW-1:0] out_pay
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in, den_ff;
   logic [DW-1:0] dvd_ff;
   logic [QW-1:0] quo_ff;
   logic [PW-1:0] pay_ff;
   logic [RW:0]   trial, diff;
   logic          ge;

   always_comb begin
      trial  = {in_rem, in_dvd[DW-1]};
      ge     = trial >= {1'b0, in_den};
      diff   = trial - {1'b0, in_den};
      rem_in = ge ? diff[RW-1:0] : trial[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         dvd_ff <= in_dvd << 1;
         quo_ff <= {in_quo[QW-2:0], ge};
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_dvd   = dvd_ff;
   assign out_quo   = quo_ff;
   assign out_pay   = pay_ff;

endmodule

/* design/peqce_cordic_cell.sv */
// ----------------------------------------------------------------------------
// peqce_cordic_cell
// One CORDIC rotation step in Q4.30, angle in 2^-32 turn units.
// ----------------------------------------------------------------------------
module peqce_cordic_cell #(
   parameter int STAGE = 0,
   parameter int PW    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  peqce_pkg::cordic_word_type in_x,
   input  peqce_pkg::cordic_word_type in_y,
   input  peqce_pkg::cordic_word_type in_z,
   input  logic [PW-1:0]              in_pay,
   output logic                       out_valid,
   output peqce_pkg::cordic_word_type out_x,
   output peqce_pkg::cordic_word_type out_y,
   output peqce_pkg::cordic_word_type out_z,
   output logic [PW-1:0]              out_pay
);

   localparam peqce_pkg::cordic_word_type ATAN =
      peqce_pkg::cordic_word_type'({2'b00, peqce_pkg::ATAN_TURN[STAGE]});

   logic                       valid_ff;
   peqce_pkg::cordic_word_type x_ff, y_ff, z_ff, x_in, y_in, z_in, dx, dy;
   logic [PW-1:0]              pay_ff;

   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[peqce_pkg::CORDIC_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_pay   = pay_ff;

endmodule
